// ----- rtl/gba_pkg.sv -----
// Shared types and constants for the bump allocator.
// Used by gba_ctrl, gba_datapath and guest_bump_allocator; depends on nothing.
package gba_pkg;

  localparam int unsigned AddrW = 64;

  typedef enum logic [2:0] {
    REQ_INIT     = 3'd0,
    REQ_ALLOC    = 3'd1,
    REQ_REALLOC  = 3'd2,
    REQ_FREE     = 3'd3,
    REQ_SIZE     = 3'd4,
    REQ_CONTAINS = 3'd5,
    REQ_RSVD6    = 3'd6,
    REQ_RSVD7    = 3'd7
  } req_e;

  typedef enum logic [2:0] {
    ST_OK         = 3'd0,
    ST_EXHAUSTED  = 3'd1,
    ST_NOT_LIVE   = 3'd2,
    ST_BAD_REGION = 3'd3,
    ST_TABLE_FULL = 3'd4
  } status_e;

  localparam logic [1:0] CFG_HEAP_BASE  = 2'd0;
  localparam logic [1:0] CFG_HEAP_BYTES = 2'd1;
  localparam logic [1:0] CFG_ALIGN_LOG2 = 2'd2;
  localparam logic [1:0] CFG_BLOCK_GAP  = 2'd3;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic latch;      // capture the request beat
    logic plan;       // register the bump plan
    logic scan_clr;   // reset the table scan
    logic scan_step;  // examine one table entry
    logic rd_entry;   // read the size of the matched entry
    logic commit;     // produce the result and update state
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic scan_last;
  } sts_t;

endpackage

// ----- rtl/gba_ctrl.sv -----
// Controller state machine for the bump allocator.
// Depends on gba_pkg; drives gba_datapath through cmd_t.
module gba_ctrl (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          start,
  input  gba_pkg::sts_t sts_i,
  output gba_pkg::cmd_t cmd_o,
  output logic          busy
);

  typedef enum logic [2:0] {
    S_IDLE, S_PLAN, S_SCAN, S_READ, S_WAIT, S_DONE
  } state_e;

  state_e state_q;

  // State register; commands decoded from the state.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      unique case (state_q)
        S_IDLE: if (start) state_q <= S_PLAN;
        S_PLAN: state_q <= S_SCAN;
        S_SCAN: if (sts_i.scan_last) state_q <= S_READ;
        S_READ: state_q <= S_WAIT;
        S_WAIT: state_q <= S_DONE;
        S_DONE: state_q <= S_IDLE;
        default: state_q <= S_IDLE;
      endcase
    end
  end

  // The size read waits until the compare of the last table entry has settled.
  always_comb begin
    cmd_o           = '0;
    cmd_o.latch     = (state_q == S_IDLE) && start;
    cmd_o.plan      = (state_q == S_PLAN);
    cmd_o.scan_clr  = (state_q == S_PLAN);
    cmd_o.scan_step = (state_q == S_SCAN);
    cmd_o.rd_entry  = (state_q == S_WAIT);
    cmd_o.commit    = (state_q == S_DONE);
  end

  assign busy = (state_q != S_IDLE);

endmodule

// ----- rtl/gba_datapath.sv -----
// Datapath of the bump allocator: registers, live table, bump arithmetic.
// Depends on gba_pkg; sequenced by gba_ctrl.
module gba_datapath #(
  parameter int unsigned LIVE_ENTRIES = 64
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  gba_pkg::cmd_t cmd_i,
  output gba_pkg::sts_t sts_o,
  input  logic [2:0]    req_type_i,
  input  logic [63:0]   block_addr_i,
  input  logic [63:0]   request_bytes_i,
  input  logic          want_zeroed_i,
  input  logic [63:0]   heap_base_i,
  input  logic [63:0]   heap_bytes_i,
  input  logic [3:0]    align_log2_i,
  input  logic [11:0]   block_gap_i,
  output logic          done_o,
  output logic [2:0]    status_o,
  output logic [63:0]   new_addr_o,
  output logic [63:0]   found_bytes_o,
  output logic          hit_o,
  output logic [63:0]   copy_from_o,
  output logic [63:0]   copy_bytes_o,
  output logic [63:0]   fill_start_o,
  output logic [63:0]   fill_bytes_o,
  output logic [63:0]   heap_top_o,
  output logic [63:0]   alloc_total_o
);

  localparam int unsigned IdxW = (LIVE_ENTRIES > 1) ? $clog2(LIVE_ENTRIES) : 1;
  localparam int unsigned CntW = $clog2(LIVE_ENTRIES + 1);
  localparam logic [CntW-1:0] LastIdx = CntW'(LIVE_ENTRIES - 1);

  // Request beat registers.
  gba_pkg::req_e req_q;
  logic [63:0] addr_q, rbytes_q, sz_q;
  logic        zero_q;

  // Allocator state.
  logic [63:0] top_q, limit_q, count_q;
  logic [LIVE_ENTRIES-1:0] valid_q;
  logic [63:0] live_addr_mem [LIVE_ENTRIES];
  logic [63:0] live_size_mem [LIVE_ENTRIES];

  // Scan state.
  logic [CntW-1:0] scan_q;
  logic [IdxW-1:0] scan_idx;
  logic            free_found_q;
  logic            match_hit_q;
  logic [IdxW-1:0] match_idx_q, free_idx_q;
  logic [63:0]     scan_addr_q;
  logic [63:0]     entry_size_q;

  // Plan results.
  logic        fit_q;
  logic [63:0] next_top_q;
  logic        init_ok_q;
  logic [63:0] init_top_q;

  assign scan_idx        = scan_q[IdxW-1:0];
  assign sts_o.scan_last = (scan_q == LastIdx);

  // Capture the request beat.
  always_ff @(posedge clk_i) begin
    if (cmd_i.latch) begin
      req_q    <= gba_pkg::req_e'(req_type_i);
      addr_q   <= block_addr_i;
      rbytes_q <= request_bytes_i;
      sz_q     <= (request_bytes_i == 64'd0) ? 64'd1 : request_bytes_i;
      zero_q   <= want_zeroed_i;
    end
  end

  // Bump plan from the latched beat, init check from the configuration.
  logic [63:0] amask, avail, end_a, rem, pad, ipad, irem;
  logic [64:0] hsum;
  logic        pre_ok;
  always_comb begin
    amask  = (64'd1 << align_log2_i) - 64'd1;
    avail  = limit_q - top_q;
    pre_ok = !(top_q > limit_q) && !(sz_q > avail) &&
             !({52'd0, block_gap_i} > (avail - sz_q));
    end_a  = top_q + sz_q + {52'd0, block_gap_i};
    rem    = end_a & amask;
    pad    = (rem == 64'd0) ? 64'd0 : (amask + 64'd1) - rem;
    irem   = heap_base_i & amask;
    ipad   = (irem == 64'd0) ? 64'd0 : (amask + 64'd1) - irem;
    hsum   = {1'b0, heap_base_i} + {1'b0, heap_bytes_i};
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.plan) begin
      fit_q      <= pre_ok && !(pad > (limit_q - end_a));
      next_top_q <= end_a + pad;
      init_ok_q  <= (heap_bytes_i != 64'd0) && !hsum[64] && (ipad < heap_bytes_i);
      init_top_q <= heap_base_i + ipad;
    end
  end

  // Table scan: one entry a cycle, first match and first free slot.
  logic entry_match;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      scan_q        <= '0;
      free_found_q  <= 1'b0;
      free_idx_q    <= '0;
    end else if (cmd_i.scan_clr) begin
      scan_q        <= '0;
      free_found_q  <= 1'b0;
    end else if (cmd_i.scan_step) begin
      if (!sts_o.scan_last) scan_q <= scan_q + 1'b1;
      if (!free_found_q && !valid_q[scan_idx]) begin
        free_found_q <= 1'b1;
        free_idx_q   <= scan_idx;
      end
    end
  end

  // Registered table read of the scanned address; compared in the following cycle.
  logic [IdxW-1:0] cmp_idx_q;
  logic            cmp_en_q;
  always_ff @(posedge clk_i) begin
    scan_addr_q <= live_addr_mem[scan_idx];
    cmp_idx_q   <= scan_idx;
  end
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cmp_en_q <= 1'b0;
    end else begin
      cmp_en_q <= cmd_i.scan_step;
    end
  end
  always_ff @(posedge clk_i) begin
    if (cmp_en_q && !match_hit_q && valid_q[cmp_idx_q] &&
        (scan_addr_q == addr_q)) begin
      match_idx_q <= cmp_idx_q;
    end
  end
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      match_hit_q <= 1'b0;
    end else if (cmd_i.scan_clr) begin
      match_hit_q <= 1'b0;
    end else if (cmp_en_q && valid_q[cmp_idx_q] && (scan_addr_q == addr_q)) begin
      match_hit_q <= 1'b1;
    end
  end
  assign entry_match = match_hit_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.rd_entry) entry_size_q <= live_size_mem[match_idx_q];
  end

  // Result and state update.
  logic [63:0] kept;
  always_comb kept = (entry_size_q < sz_q) ? entry_size_q : sz_q;

  logic is_alloc;
  always_comb is_alloc = (req_q == gba_pkg::REQ_ALLOC) ||
                         ((req_q == gba_pkg::REQ_REALLOC) && (addr_q == 64'd0));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      top_q         <= '0;
      limit_q       <= '0;
      count_q       <= '0;
      valid_q       <= '0;
      done_o        <= 1'b0;
      status_o      <= gba_pkg::ST_OK;
      new_addr_o    <= '0;
      found_bytes_o <= '0;
      hit_o         <= 1'b0;
      copy_from_o   <= '0;
      copy_bytes_o  <= '0;
      fill_start_o  <= '0;
      fill_bytes_o  <= '0;
      heap_top_o    <= '0;
      alloc_total_o <= '0;
    end else begin
      done_o <= cmd_i.commit;
      if (cmd_i.commit) begin
        status_o      <= gba_pkg::ST_OK;
        new_addr_o    <= '0;
        found_bytes_o <= '0;
        hit_o         <= 1'b0;
        copy_from_o   <= '0;
        copy_bytes_o  <= '0;
        fill_start_o  <= '0;
        fill_bytes_o  <= '0;
        heap_top_o    <= top_q;
        alloc_total_o <= count_q;
        if (req_q == gba_pkg::REQ_INIT) begin
          if (!init_ok_q) begin
            status_o <= gba_pkg::ST_BAD_REGION;
          end else begin
            limit_q       <= heap_base_i + heap_bytes_i;
            top_q         <= init_top_q;
            count_q       <= '0;
            valid_q       <= '0;
            heap_top_o    <= init_top_q;
            alloc_total_o <= '0;
          end
        end else if (is_alloc) begin
          if (!fit_q) begin
            status_o <= gba_pkg::ST_EXHAUSTED;
          end else if (!free_found_q) begin
            status_o <= gba_pkg::ST_TABLE_FULL;
          end else begin
            valid_q[free_idx_q] <= 1'b1;
            new_addr_o    <= top_q;
            if (zero_q) begin
              fill_start_o <= top_q;
              fill_bytes_o <= sz_q;
            end
            top_q         <= next_top_q;
            count_q       <= count_q + 64'd1;
            heap_top_o    <= next_top_q;
            alloc_total_o <= count_q + 64'd1;
          end
        end else if (req_q == gba_pkg::REQ_REALLOC) begin
          if (!entry_match) begin
            status_o <= gba_pkg::ST_NOT_LIVE;
          end else if (!fit_q) begin
            status_o <= gba_pkg::ST_EXHAUSTED;
          end else begin
            new_addr_o   <= top_q;
            copy_from_o  <= addr_q;
            copy_bytes_o <= kept;
            if (zero_q && (kept < rbytes_q)) begin
              fill_start_o <= top_q + kept;
              fill_bytes_o <= rbytes_q - kept;
            end
            top_q         <= next_top_q;
            count_q       <= count_q + 64'd1;
            heap_top_o    <= next_top_q;
            alloc_total_o <= count_q + 64'd1;
          end
        end else if (req_q == gba_pkg::REQ_FREE) begin
          if (entry_match) begin
            valid_q[match_idx_q] <= 1'b0;
            hit_o <= 1'b1;
          end
        end else if (req_q == gba_pkg::REQ_SIZE) begin
          if (entry_match) begin
            found_bytes_o <= entry_size_q;
            hit_o         <= 1'b1;
          end
        end else if (req_q == gba_pkg::REQ_CONTAINS) begin
          hit_o <= (addr_q >= heap_base_i) && (addr_q < top_q);
        end
      end
    end
  end

  // Live table memory writes: new entry on allocate, replacement on move.
  logic        wr_en;
  logic [IdxW-1:0] wr_idx;
  always_comb begin
    wr_en  = 1'b0;
    wr_idx = free_idx_q;
    if (cmd_i.commit && fit_q) begin
      if (is_alloc && free_found_q) begin
        wr_en = 1'b1;
      end else if ((req_q == gba_pkg::REQ_REALLOC) && !is_alloc && entry_match) begin
        wr_en  = 1'b1;
        wr_idx = match_idx_q;
      end
    end
  end
  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      live_addr_mem[wr_idx] <= top_q;
      live_size_mem[wr_idx] <= sz_q;
    end
  end

endmodule

// ----- rtl/guest_bump_allocator.sv -----
// Bump allocator top level: configuration registers, controller and datapath.
// One request at a time: a new start is taken at the edge that ends the done strobe.
// Each request plans, scans the live table one entry a cycle, reads the size of
// the matched entry and commits. Reset clears the pointers, the count and the
// live valid bits at once and loads align_log2 = 4, block_gap = 16.
// Results are a single-cycle strobe; the receiver cannot stall.
module guest_bump_allocator #(
  parameter int unsigned LIVE_ENTRIES = 64
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start,
  output logic        busy,
  input  logic [2:0]  req_type_i,
  input  logic [63:0] block_addr_i,
  input  logic [63:0] request_bytes_i,
  input  logic        want_zeroed_i,
  input  logic        cfg_we_i,
  input  logic [1:0]  cfg_idx_i,
  input  logic [63:0] cfg_wdata_i,
  output logic        done_o,
  output logic [2:0]  status_o,
  output logic [63:0] new_addr_o,
  output logic [63:0] found_bytes_o,
  output logic        hit_o,
  output logic [63:0] copy_from_o,
  output logic [63:0] copy_bytes_o,
  output logic [63:0] fill_start_o,
  output logic [63:0] fill_bytes_o,
  output logic [63:0] heap_top_o,
  output logic [63:0] alloc_total_o
);

  logic [63:0] heap_base_q, heap_bytes_q;
  logic [3:0]  align_log2_q;
  logic [11:0] block_gap_q;

  // Configuration register writes.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      heap_base_q  <= '0;
      heap_bytes_q <= '0;
      align_log2_q <= 4'd4;
      block_gap_q  <= 12'd16;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        gba_pkg::CFG_HEAP_BASE:  heap_base_q  <= cfg_wdata_i;
        gba_pkg::CFG_HEAP_BYTES: heap_bytes_q <= cfg_wdata_i;
        gba_pkg::CFG_ALIGN_LOG2: align_log2_q <= cfg_wdata_i[3:0];
        gba_pkg::CFG_BLOCK_GAP:  block_gap_q  <= cfg_wdata_i[11:0];
        default: ;
      endcase
    end
  end

  gba_pkg::cmd_t cmd;
  gba_pkg::sts_t sts;

  gba_ctrl u_ctrl (
    .clk_i, .rst_ni, .start, .sts_i(sts), .cmd_o(cmd), .busy
  );

  gba_datapath #(.LIVE_ENTRIES(LIVE_ENTRIES)) u_dp (
    .clk_i, .rst_ni, .cmd_i(cmd), .sts_o(sts),
    .req_type_i, .block_addr_i, .request_bytes_i, .want_zeroed_i,
    .heap_base_i(heap_base_q), .heap_bytes_i(heap_bytes_q),
    .align_log2_i(align_log2_q), .block_gap_i(block_gap_q),
    .done_o, .status_o, .new_addr_o, .found_bytes_o, .hit_o,
    .copy_from_o, .copy_bytes_o, .fill_start_o, .fill_bytes_o,
    .heap_top_o, .alloc_total_o
  );

  // A result strobe only follows a busy period.
  assert property (@(posedge clk_i) disable iff (!rst_ni) done_o |-> $past(busy))
    else $error("done without a request in flight");
  // A start taken while idle raises busy.
  assert property (@(posedge clk_i) disable iff (!rst_ni) (start && !busy) |=> busy)
    else $error("accepted request did not raise busy");
  // The result strobe lasts one cycle and comes with the controller idle.
  assert property (@(posedge clk_i) disable iff (!rst_ni) done_o |-> !busy ##1 !done_o)
    else $error("result strobe overlapped a busy period or lasted too long");

endmodule
